>>> rtl/indexed_list_insert_delete_defines.svh
// ============================================================================
// indexed_list_insert_delete_defines.svh
// Assertion macros shared by the list checker. The clock is i_clk and the
// active-low reset is i_rst_n in every module that uses them.
// ============================================================================
`ifndef INDEXED_LIST_INSERT_DELETE_DEFINES_SVH
`define INDEXED_LIST_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, off during reset
`define ILD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset
`define ILD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication, checked through reset as well
`define ILD_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ild_pkg.sv
// ============================================================================
// ild_pkg
// Shared types, codes, field widths and elaboration helpers of the list block.
// ============================================================================
package ild_pkg;

    // Field widths of a request and a response
    localparam int OP_W       = 3;
    localparam int POS_W      = 6;
    localparam int WORD_W     = 64;
    localparam int COUNT_W    = 7;
    localparam int STATUS_W   = 2;

    // Default number of cells
    localparam int CAPACITY_DEF = 64;

    // Fan-in of one read-out tree node, as a power of two
    localparam int TREE_FANIN_LOG2 = 3;
    localparam int TREE_FANIN      = 1 << TREE_FANIN_LOG2;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 3'd0,
        OP_INSERT    = 3'd1,
        OP_OVERWRITE = 3'd2,
        OP_DELETE    = 3'd3,
        OP_DROP      = 3'd4,
        OP_CLEAR     = 3'd5,
        OP_READ      = 3'd6
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_POS = 2'd1,
        STAT_FULL    = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WAIT = 1'b1
    } t_state;

    // Per-transaction command broadcast to every cell
    typedef struct packed {
        logic ins;  // open a gap at the index, store the word there
        logic del;  // close the gap at the index
        logic wr;   // store the word at the index
    } t_cell_ctl;

    // Nodes on one tree level (level 0 is the row of taps)
    function automatic int tree_nodes(input int n, input int lvl);
        int c;
        c = n;
        for (int k = 0; k < lvl; k++) begin
            c = (c + TREE_FANIN - 1) >> TREE_FANIN_LOG2;
        end
        return c;
    endfunction

    // Registered levels needed to reduce n taps to one node
    function automatic int tree_levels(input int n);
        int c;
        int lvl;
        c   = n;
        lvl = 0;
        while (c > 1) begin
            c   = (c + TREE_FANIN - 1) >> TREE_FANIN_LOG2;
            lvl = lvl + 1;
        end
        return lvl;
    endfunction

    // Offset of a level's first node in the flat node array (levels from 1)
    function automatic int tree_off(input int n, input int lvl);
        int s;
        s = 0;
        for (int m = 1; m < lvl; m++) begin
            s = s + tree_nodes(n, m);
        end
        return s;
    endfunction

endpackage

>>> rtl/ild_if.sv
// ============================================================================
// ild_if
// Request and response channels of the list block: valid/ready plus payload.
// ============================================================================
interface ild_req_if;
    logic                          valid;
    logic                          ready;
    logic [ild_pkg::OP_W-1:0]      op;
    logic [ild_pkg::POS_W-1:0]     position;
    logic [ild_pkg::WORD_W-1:0]    value;

    modport source (output valid, output op, output position, output value,
                    input ready);
    modport sink   (input valid, input op, input position, input value,
                    output ready);
endinterface

interface ild_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ild_pkg::WORD_W-1:0]    read_word;
    logic [ild_pkg::COUNT_W-1:0]   count;
    logic [ild_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output read_word, output count, output status,
                    input ready);
    modport sink   (input valid, input read_word, input count, input status,
                    output ready);
endinterface

>>> rtl/ild_cell.sv
// ============================================================================
// ild_cell
// One list entry: holds a word, loads a new word or takes its neighbor's word
// on insert and delete, and presents its word on the read tap when selected.
// ============================================================================
module ild_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic                          i_clk,
    input  ild_pkg::t_cell_ctl            i_ctl,
    input  logic [IDX_W-1:0]              i_idx,
    input  logic [CNT_W-1:0]              i_count,
    input  logic [ild_pkg::WORD_W-1:0]    i_value,
    input  logic [ild_pkg::WORD_W-1:0]    i_left,
    input  logic [ild_pkg::WORD_W-1:0]    i_right,
    input  logic                          i_rd_en,
    input  logic [IDX_W-1:0]              i_rd_pos,
    output logic [ild_pkg::WORD_W-1:0]    o_word,
    output logic [ild_pkg::WORD_W-1:0]    o_tap
);

    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_CNT   = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_NEXT  = CNT_W'(INDEX + 1);

    logic [ild_pkg::WORD_W-1:0] r_word;
    logic [ild_pkg::WORD_W-1:0] n_word;

    // Pick the next word: new value, word from below, word from above, or hold
    always_comb begin
        n_word = r_word;
        priority if ((i_ctl.wr || i_ctl.ins) && i_idx == MY_IDX) begin
            n_word = i_value;
        end else if (i_ctl.ins && i_idx < MY_IDX && MY_CNT <= i_count) begin
            n_word = i_left;
        end else if (i_ctl.del && i_idx <= MY_IDX && MY_NEXT < i_count) begin
            n_word = i_right;
        end else begin
            n_word = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

    // Show the word on the read tap only when this cell is addressed
    assign o_tap = (i_rd_en && i_rd_pos == MY_IDX) ? r_word : '0;

endmodule

>>> rtl/ild_or_tree.sv
// ============================================================================
// ild_or_tree
// Registered OR-reduction of the cell read taps, eight children at most per
// node per level. At most one tap is nonzero: the root has the selected word.
// ============================================================================
module ild_or_tree #(
    parameter int N      = 64,
    parameter int LEVELS = ild_pkg::tree_levels(N)
) (
    input  logic                          i_clk,
    input  logic [ild_pkg::WORD_W-1:0]    i_tap [N],
    output logic [ild_pkg::WORD_W-1:0]    o_root
);

    localparam int TOTAL = ild_pkg::tree_off(N, LEVELS + 1);

    logic [ild_pkg::WORD_W-1:0] r_tree [TOTAL];

    for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
        localparam int NN   = ild_pkg::tree_nodes(N, l);
        localparam int PN   = ild_pkg::tree_nodes(N, l - 1);
        localparam int OFF  = ild_pkg::tree_off(N, l);
        localparam int POFF = ild_pkg::tree_off(N, l - 1);

        for (genvar j = 0; j < NN; j++) begin : g_node
            logic [ild_pkg::WORD_W-1:0] n_node;

            // OR the children of this node, taps on the first level
            always_comb begin
                n_node = '0;
                for (int k = 0; k < ild_pkg::TREE_FANIN; k++) begin
                    if (j * ild_pkg::TREE_FANIN + k < PN) begin
                        if (l == 1) begin
                            n_node = n_node | i_tap[j * ild_pkg::TREE_FANIN + k];
                        end else begin
                            n_node = n_node
                                   | r_tree[POFF + j * ild_pkg::TREE_FANIN + k];
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                r_tree[OFF + j] <= n_node;
            end
        end
    end

    assign o_root = r_tree[TOTAL - 1];

endmodule

>>> rtl/indexed_list_insert_delete.sv
// ============================================================================
// indexed_list_insert_delete
// Ordered list of up to CAPACITY 64-bit words held in a row of cells. A
// request appends, inserts, overwrites, deletes, drops the last entry, clears
// or reads, and returns one response with the read word (zero unless a good
// read), the count held afterwards (low 7 bits) and a status: ok, position
// not below the count, or list full. A failing request leaves the list as it
// was. All list changes take effect in the cycle of the transaction, every
// cell moving to or from its neighbor at once. The response waits on the
// registered read-out tree over the cells, LEVELS levels deep (that is
// ceil(log8(CAPACITY)), 2 for 64 entries). The next request is taken when
// the response is taken, so one request at a time is in the block. No
// clearing pass follows reset: entries are only read after being written.
// ============================================================================
module indexed_list_insert_delete #(
    parameter int CAPACITY = ild_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ild_req_if.sink       i_req,
    ild_rsp_if.source     o_rsp
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > ild_pkg::POS_W) ? CNT_W : ild_pkg::POS_W;
    localparam int LEVELS = ild_pkg::tree_levels(CAPACITY);
    localparam int WAIT_W = $clog2(LEVELS + 1);

    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CAPACITY);
    localparam logic [WAIT_W-1:0] WAIT_LOAD = WAIT_W'(LEVELS);

    // Control state
    ild_pkg::t_state            r_state;
    ild_pkg::t_state            n_state;
    logic [WAIT_W-1:0]          r_wait;
    logic                       r_out_valid;
    logic [CNT_W-1:0]           r_count;
    ild_pkg::t_status           r_status;
    logic                       r_rd_en;
    logic [IDX_W-1:0]           r_rd_pos;

    // Decoded request
    ild_pkg::t_op               req_op;
    logic                       accept;
    logic                       done;
    logic                       pos_ok;
    logic                       full;
    logic [CNT_W-1:0]           n_count;
    ild_pkg::t_status           n_status;
    logic                       n_rd_en;
    ild_pkg::t_cell_ctl         dec_ctl;
    ild_pkg::t_cell_ctl         cell_ctl;
    logic [IDX_W-1:0]           cell_idx;

    // Cell row
    logic [ild_pkg::WORD_W-1:0] cell_word [CAPACITY];
    logic [ild_pkg::WORD_W-1:0] cell_tap  [CAPACITY];
    logic [ild_pkg::WORD_W-1:0] root_word;

    assign req_op = ild_pkg::t_op'(i_req.op);
    assign pos_ok = CMP_W'(i_req.position) < CMP_W'(r_count);
    assign full   = (r_count == FULL_CNT);

    // Decode the operation into cell commands, next count and status
    always_comb begin
        dec_ctl  = '0;
        cell_idx = IDX_W'(i_req.position);
        n_count  = r_count;
        n_status = ild_pkg::STAT_OK;
        n_rd_en  = 1'b0;
        unique case (req_op)
            ild_pkg::OP_APPEND: begin
                cell_idx = IDX_W'(r_count);
                if (full) begin
                    n_status = ild_pkg::STAT_FULL;
                end else begin
                    dec_ctl.wr = 1'b1;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            ild_pkg::OP_INSERT: begin
                if (!pos_ok) begin
                    n_status = ild_pkg::STAT_BAD_POS;
                end else if (full) begin
                    n_status = ild_pkg::STAT_FULL;
                end else begin
                    dec_ctl.ins = 1'b1;
                    n_count     = r_count + CNT_W'(1);
                end
            end
            ild_pkg::OP_OVERWRITE: begin
                if (!pos_ok) begin
                    n_status = ild_pkg::STAT_BAD_POS;
                end else begin
                    dec_ctl.wr = 1'b1;
                end
            end
            ild_pkg::OP_DELETE: begin
                if (!pos_ok) begin
                    n_status = ild_pkg::STAT_BAD_POS;
                end else begin
                    dec_ctl.del = 1'b1;
                    n_count     = r_count - CNT_W'(1);
                end
            end
            ild_pkg::OP_DROP: begin
                if (r_count != '0) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            ild_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            ild_pkg::OP_READ: begin
                if (!pos_ok) begin
                    n_status = ild_pkg::STAT_BAD_POS;
                end else begin
                    n_rd_en = 1'b1;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ild_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = ild_pkg::ST_WAIT;
                end
            end
            ild_pkg::ST_WAIT: begin
                if (r_wait == '0) begin
                    n_state = ild_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ild_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs: take a request only with the response slot free
    always_comb begin
        i_req.ready = 1'b0;
        done        = 1'b0;
        unique case (r_state)
            ild_pkg::ST_IDLE: begin
                i_req.ready = !r_out_valid || o_rsp.ready;
            end
            ild_pkg::ST_WAIT: begin
                done = (r_wait == '0);
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    assign accept   = i_req.valid && i_req.ready;
    assign cell_ctl = accept ? dec_ctl : '0;

    // Sequence control and response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ild_pkg::ST_IDLE;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_wait  <= WAIT_LOAD;
                r_count <= n_count;
            end else if (r_state == ild_pkg::ST_WAIT && r_wait != '0) begin
                r_wait <= r_wait - WAIT_W'(1);
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold status and read address of the transaction in progress
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_rd_en  <= n_rd_en;
            r_rd_pos <= IDX_W'(i_req.position);
        end
    end

    // Row of cells, each wired to its neighbors
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ild_pkg::WORD_W-1:0] left_word;
        logic [ild_pkg::WORD_W-1:0] right_word;

        if (i == 0) begin : g_first
            assign left_word = '0;
        end else begin : g_mid_l
            assign left_word = cell_word[i - 1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_word = '0;
        end else begin : g_mid_r
            assign right_word = cell_word[i + 1];
        end

        ild_cell #(
            .INDEX (i),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (cell_ctl),
            .i_idx    (cell_idx),
            .i_count  (r_count),
            .i_value  (i_req.value),
            .i_left   (left_word),
            .i_right  (right_word),
            .i_rd_en  (r_rd_en),
            .i_rd_pos (r_rd_pos),
            .o_word   (cell_word[i]),
            .o_tap    (cell_tap[i])
        );
    end

    // Collect the addressed word
    ild_or_tree #(
        .N      (CAPACITY),
        .LEVELS (LEVELS)
    ) u_tree (
        .i_clk  (i_clk),
        .i_tap  (cell_tap),
        .o_root (root_word)
    );

    // Response payload is stable from done until the next transaction
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_word = root_word;
    assign o_rsp.count     = ild_pkg::COUNT_W'(r_count);
    assign o_rsp.status    = r_status;

endmodule

>>> rtl/ild_checker.sv
// ============================================================================
// ild_checker
// Port-level checks of the list block, bound to every instance of the top.
// ============================================================================
`include "indexed_list_insert_delete_defines.svh"

module ild_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    input  logic                           i_req_ready,
    input  logic                           i_rsp_valid,
    input  logic                           i_rsp_ready,
    input  logic [ild_pkg::WORD_W-1:0]     i_rsp_read_word,
    input  logic [ild_pkg::COUNT_W-1:0]    i_rsp_count,
    input  logic [ild_pkg::STATUS_W-1:0]   i_rsp_status
);

    logic req_acc;
    logic rsp_stall;
    logic rsp_fail;
    logic [ild_pkg::WORD_W+ild_pkg::COUNT_W+ild_pkg::STATUS_W-1:0] rsp_payload;

    assign req_acc     = i_req_valid && i_req_ready;
    assign rsp_stall   = i_rsp_valid && !i_rsp_ready;
    assign rsp_fail    = i_rsp_valid && (i_rsp_status != ild_pkg::STAT_OK);
    assign rsp_payload = {i_rsp_read_word, i_rsp_count, i_rsp_status};

    // Reset leaves no response pending
    `ILD_ASSERT_NEXT_ALWAYS(a_rst_no_rsp, !i_rst_n, !i_rsp_valid, "response valid after reset")

    // A taken request never sees its response in the next cycle
    `ILD_ASSERT_NEXT(a_acc_latency, req_acc, !i_rsp_valid, "response too early after request")

    // Hold off requests while a response is stalled
    `ILD_ASSERT_NOW(a_no_acc_stall, rsp_stall, !req_acc, "request taken over a stalled response")

    // Only a good read returns a word
    `ILD_ASSERT_NOW(a_fail_zero, rsp_fail, i_rsp_read_word == '0, "failed request returned a word")

    // Hold a stalled response
    `ILD_ASSERT_NEXT(a_rsp_hold, rsp_stall, i_rsp_valid && $stable(rsp_payload), "stalled response changed")

endmodule

bind indexed_list_insert_delete ild_checker u_ild_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_read_word (o_rsp.read_word),
    .i_rsp_count     (o_rsp.count),
    .i_rsp_status    (o_rsp.status)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Checks the indexed list block against a cycle-free model of the list held
// here. A short table of directed requests runs first: the empty list, the
// position at and past the count, unused op code, drop and clear on an
// empty list. Random episodes follow that grow the list to full, shrink it
// or mix all operations. Every response is compared field by field with the
// oldest expected response. The request side sends in bursts with gaps, and
// the response side stalls on its own pattern. One long response hold-off
// fills the block, and one pause drains it.
// ============================================================================
module testbench;
    import ild_pkg::*;

    localparam int CLK_HALF_NS     = 2;
    localparam int RESET_CYCLES    = 10;
    localparam int RANDOM_ITEMS    = 1200;
    localparam int RSP_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int TIMEOUT_NS      = 2_000_000;
    localparam int LIST_CAP        = CAPACITY_DEF;

    // Op code with no operation behind it
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [COUNT_W-1:0] count;
        t_status            status;
    } t_list_result;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] value;
        bit                typed;
        t_list_result      result;
    } t_stim_row;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } t_mix;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ild_req_if req_bus ();
    ild_rsp_if rsp_bus ();

    indexed_list_insert_delete i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Model of the list contents
    logic [WORD_W-1:0] list_words [LIST_CAP];
    int                list_len;

    t_list_result pending_results [$];
    t_stim_row    directed_rows [$];
    bit           failed;
    bit           hold_rsp;
    int           burst_left;

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Apply one request to the list model and return its response
    function automatic t_list_result apply_list_op(input logic [OP_W-1:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [WORD_W-1:0] value);
        t_list_result r;
        bit           pos_ok;
        r.word   = '0;
        r.status = STAT_OK;
        pos_ok   = int'(pos) < list_len;
        case (op)
            OP_APPEND: begin
                if (list_len >= LIST_CAP) begin
                    r.status = STAT_FULL;
                end else begin
                    list_words[list_len] = value;
                    list_len++;
                end
            end
            OP_INSERT: begin
                if (!pos_ok) begin
                    r.status = STAT_BAD_POS;
                end else if (list_len >= LIST_CAP) begin
                    r.status = STAT_FULL;
                end else begin
                    for (int i = list_len; i > int'(pos); i--) begin
                        list_words[i] = list_words[i-1];
                    end
                    list_words[pos] = value;
                    list_len++;
                end
            end
            OP_OVERWRITE: begin
                if (!pos_ok) r.status = STAT_BAD_POS;
                else list_words[pos] = value;
            end
            OP_DELETE: begin
                if (!pos_ok) begin
                    r.status = STAT_BAD_POS;
                end else begin
                    for (int i = int'(pos); i + 1 < list_len; i++) begin
                        list_words[i] = list_words[i+1];
                    end
                    list_len--;
                end
            end
            OP_DROP: begin
                if (list_len != 0) list_len--;
            end
            OP_CLEAR: begin
                list_len = 0;
            end
            OP_READ: begin
                if (!pos_ok) r.status = STAT_BAD_POS;
                else r.word = list_words[pos];
            end
            default: begin
            end
        endcase
        r.count = COUNT_W'(list_len);
        return r;
    endfunction

    function automatic void add_row(input logic [OP_W-1:0] op,
                                    input logic [POS_W-1:0] pos,
                                    input logic [WORD_W-1:0] value,
                                    input bit typed,
                                    input logic [WORD_W-1:0] word,
                                    input logic [COUNT_W-1:0] count,
                                    input t_status status);
        t_stim_row row;
        row.op            = op;
        row.pos           = pos;
        row.value         = value;
        row.typed         = typed;
        row.result.word   = word;
        row.result.count  = count;
        row.result.status = status;
        directed_rows.push_back(row);
    endfunction

    // Offer one request in the current burst, wait for the transaction, then
    // queue its expected response (typed one if given, else predicted)
    task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [WORD_W-1:0] value, input bit typed,
                             input t_list_result typed_result);
        int           gap;
        t_list_result predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                req_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_bus.valid    <= 1'b1;
        req_bus.op       <= op;
        req_bus.position <= pos;
        req_bus.value    <= value;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        predicted = apply_list_op(op, pos, value);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    function automatic logic [OP_W-1:0] pick_op(input t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW: begin
                if (r < 50) return OP_APPEND;
                if (r < 78) return OP_INSERT;
                if (r < 84) return OP_READ;
                if (r < 90) return OP_OVERWRITE;
                if (r < 94) return OP_DELETE;
                if (r < 98) return OP_DROP;
                return OP_UNUSED;
            end
            MIX_SHRINK: begin
                if (r < 30) return OP_DELETE;
                if (r < 55) return OP_DROP;
                if (r < 70) return OP_READ;
                if (r < 80) return OP_OVERWRITE;
                if (r < 88) return OP_APPEND;
                if (r < 93) return OP_INSERT;
                if (r < 96) return OP_CLEAR;
                return OP_UNUSED;
            end
            default: begin
                if (r < 16) return OP_APPEND;
                if (r < 32) return OP_INSERT;
                if (r < 48) return OP_OVERWRITE;
                if (r < 62) return OP_DELETE;
                if (r < 70) return OP_DROP;
                if (r < 72) return OP_CLEAR;
                if (r < 97) return OP_READ;
                return OP_UNUSED;
            end
        endcase
    endfunction

    // Mostly a held entry, sometimes the count itself, else anything
    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (list_len > 0 && r < 80) return POS_W'($urandom_range(0, list_len - 1));
        if (r < 88 && list_len < LIST_CAP) return POS_W'(list_len);
        return POS_W'($urandom_range(0, LIST_CAP - 1));
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
        return {$urandom, $urandom};
    endfunction

    // Response side: stall on a pattern, or hold off for a long stretch
    initial begin
        int   stretch;
        int   phase;
        t_mix mode;
        stretch = 0;
        phase   = 0;
        mode    = MIX_EVEN;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_rsp) begin
                rsp_bus.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(posedge i_clk);
                hold_rsp = 1'b0;
            end else begin
                if (stretch == 0) begin
                    mode    = t_mix'($urandom_range(0, 2));
                    stretch = $urandom_range(10, 150);
                end
                stretch--;
                phase++;
                case (mode)
                    MIX_GROW:   rsp_bus.ready <= 1'b1;
                    MIX_SHRINK: rsp_bus.ready <= ($urandom_range(0, 9) < 6);
                    default:    rsp_bus.ready <= (phase % 5 != 4);
                endcase
            end
        end
    end

    // Compare each response transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: response with none expected: word %h count %0d status %0d",
                         $time, rsp_bus.read_word, rsp_bus.count, rsp_bus.status);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (rsp_bus.read_word !== want.word) begin
                    $display("%0t: read_word expected %h actual %h",
                             $time, want.word, rsp_bus.read_word);
                    failed = 1'b1;
                end
                if (rsp_bus.count !== want.count) begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.count, rsp_bus.count);
                    failed = 1'b1;
                end
                if (rsp_bus.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp_bus.status);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("indexed_list_insert_delete: mismatch");
        $finish;
    end

    initial begin
        t_list_result none;
        t_stim_row    row;
        t_mix         mix;
        int           episode_left;
        int           sent;
        none       = '0;
        failed     = 1'b0;
        hold_rsp   = 1'b0;
        burst_left = 0;
        list_len   = 0;
        for (int i = 0; i < LIST_CAP; i++) list_words[i] = '0;

        i_rst_n          <= 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.op       <= OP_APPEND;
        req_bus.position <= '0;
        req_bus.value    <= '0;

        // Empty list, position at and past the count, unused code, extremes
        add_row(OP_READ,      6'd0,  '0, 1, '0, 7'd0, STAT_BAD_POS);
        add_row(OP_DROP,      6'd0,  '0, 1, '0, 7'd0, STAT_OK);
        add_row(OP_CLEAR,     6'd0,  '0, 1, '0, 7'd0, STAT_OK);
        add_row(OP_UNUSED,    6'd63, '1, 1, '0, 7'd0, STAT_OK);
        add_row(OP_INSERT,    6'd0,  '1, 1, '0, 7'd0, STAT_BAD_POS);
        add_row(OP_OVERWRITE, 6'd0,  '1, 1, '0, 7'd0, STAT_BAD_POS);
        add_row(OP_DELETE,    6'd0,  '0, 1, '0, 7'd0, STAT_BAD_POS);
        add_row(OP_APPEND,    6'd63, '1, 1, '0, 7'd1, STAT_OK);
        add_row(OP_APPEND,    6'd0,  '0, 1, '0, 7'd2, STAT_OK);
        add_row(OP_READ,      6'd0,  '0, 1, '1, 7'd2, STAT_OK);
        add_row(OP_READ,      6'd1,  '1, 1, '0, 7'd2, STAT_OK);
        add_row(OP_READ,      6'd2,  '0, 1, '0, 7'd2, STAT_BAD_POS);
        add_row(OP_INSERT,    6'd2,  '1, 1, '0, 7'd2, STAT_BAD_POS);
        add_row(OP_INSERT,    6'd1,  64'hA5A5_A5A5_A5A5_A5A5, 0, '0, '0, STAT_OK);
        add_row(OP_OVERWRITE, 6'd0,  64'h5A5A_5A5A_5A5A_5A5A, 0, '0, '0, STAT_OK);
        add_row(OP_READ,      6'd1,  '0, 0, '0, '0, STAT_OK);
        add_row(OP_DELETE,    6'd0,  '0, 0, '0, '0, STAT_OK);
        add_row(OP_READ,      6'd0,  '0, 0, '0, '0, STAT_OK);
        add_row(OP_READ,      6'd63, '0, 1, '0, 7'd2, STAT_BAD_POS);
        add_row(OP_UNUSED,    6'd5,  '1, 1, '0, 7'd2, STAT_OK);
        add_row(OP_DROP,      6'd0,  '0, 1, '0, 7'd1, STAT_OK);
        add_row(OP_READ,      6'd0,  '0, 0, '0, '0, STAT_OK);
        add_row(OP_CLEAR,     6'd0,  '0, 1, '0, 7'd0, STAT_OK);
        add_row(OP_APPEND,    6'd0,  64'h8000_0000_0000_0001, 1, '0, 7'd1, STAT_OK);
        add_row(OP_DELETE,    6'd0,  '0, 1, '0, 7'd0, STAT_OK);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            send_item(row.op, row.pos, row.value, row.typed, row.result);
        end

        // Random episodes: grow to full, shrink, or mix everything
        sent         = 0;
        episode_left = 0;
        mix          = MIX_GROW;
        while (sent < RANDOM_ITEMS) begin
            if (episode_left == 0) begin
                episode_left = $urandom_range(40, 160);
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7: mix = MIX_GROW;
                    8, 9, 10, 11, 12:       mix = MIX_SHRINK;
                    default:                mix = MIX_EVEN;
                endcase
            end
            episode_left--;
            if (sent == RANDOM_ITEMS / 3) hold_rsp = 1'b1;
            if (sent == (2 * RANDOM_ITEMS) / 3) begin
                // Pause the request side until every response is back
                req_bus.valid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end
            send_item(pick_op(mix), pick_position(), pick_value(), 0, none);
            sent++;
        end

        // Drain outstanding responses, then let the block settle
        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed) begin
            $display("indexed_list_insert_delete: match");
        end else begin
            $display("indexed_list_insert_delete: mismatch");
        end
        $finish;
    end

endmodule
